// File: sv/bhpq_pkg.sv
// shared constants, codes, command and status types of the binary heap priority queue
`timescale 1ns / 1ps
package bhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;
  localparam int KEY_W    = 64;
  localparam int ENTRY_W  = 11;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ROOT   = 3'd1,
    RD_LAST   = 3'd2,
    RD_PARENT = 3'd3,
    RD_LEFT   = 3'd4,
    RD_RIGHT  = 3'd5
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_MOVING = 2'd1,
    WR_PARENT = 2'd2,
    WR_CHILD  = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_RDATA = 2'd1,
    RES_HELD  = 2'd2
  } res_src_t;

  typedef struct packed {
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     push_load;
    logic     dec_count;
    logic     load_last;
    logic     cap_root;
    logic     cap_left;
    logic     pos_up;
    logic     pos_down;
    logic     emit;
    status_t  res_status;
    res_src_t res_src;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_zero;
    logic lc_valid;
    logic rc_valid;
    logic up_wins;
    logic descend;
  } stat_t;

  // true when a has strictly higher priority than b
  function automatic logic outranks(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b,
                                    logic min_first);
    return min_first ? (a < b) : (a > b);
  endfunction

  // low bits of the count as reported on the result
  function automatic logic [ENTRY_W-1:0] count_field(logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[ENTRY_W-1:0];
  endfunction

endpackage

// File: sv/binary_heap_priority_queue_top.sv
// top level of the binary heap priority queue
//
// A request is taken at a rising edge with start high and busy low: operation selects
// push (key is inserted), pop (root is removed and returned) or peek (root returned).
// Each request gives exactly one result: done is high for one cycle with status,
// result_key and entry_count (keys held afterwards). The receiver cannot stall; a new
// request may be issued in the very cycle done is high.
// Sequence: a refused push, a pop or peek of an empty heap and an unused code are answered
// straight from idle; a peek reads the root and returns it; a push climbs, reading each
// parent and moving it down while the new key outranks it; a pop reads the root, then the
// last key, and ends there if that was the last key; otherwise it sifts that key down,
// reading the left and then, if present, the right child of each level, and stops when
// neither child outranks it.
// The sift loops are bounded by the single-read, single-write heap memory: one read per
// parent visited going up, up to two reads per level going down.
// min_first is written on the cfg channel (cfg_ready is always high), by the user only while
// no request is in flight (not enforced); reset empties the heap, sets smallest-key-first order.
`timescale 1ns / 1ps
module binary_heap_priority_queue_top
  import bhpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation,
  input  logic signed [KEY_W-1:0] key,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [KEY_W-1:0] result_key,
  output logic [ENTRY_W-1:0]      entry_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  bhpq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key         (key),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .done        (done),
    .status      (status),
    .result_key  (result_key),
    .entry_count (entry_count)
  );

endmodule

// File: sv/bhpq_ctrl.sv
// sequencing state machine of the binary heap priority queue
`timescale 1ns / 1ps
module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_CHK   = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_ROOT = 9'b000001000,
    S_POP_LAST = 9'b000010000,
    S_DN_CHK   = 9'b000100000,
    S_DN_LEFT  = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_PEEK     = 9'b100000000
  } state_t;

  state_t state, state_next;
  op_t    op_in;

  assign op_in = op_t'(operation);
  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = RD_NONE;
    cmd.wr_sel     = WR_NONE;
    cmd.res_status = ST_OK;
    cmd.res_src    = RES_ZERO;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op_in)
            OP_PUSH: begin
              if (stat.full) begin
                cmd.emit       = 1'b1;
                cmd.res_status = ST_FULL;
              end else begin
                cmd.push_load = 1'b1;
                state_next    = S_UP_CHK;
              end
            end
            OP_POP, OP_PEEK: begin
              if (stat.empty) begin
                cmd.emit       = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.rd_sel = RD_ROOT;
                state_next = (op_in == OP_POP) ? S_POP_ROOT : S_PEEK;
              end
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd.wr_sel = WR_MOVING;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_wins) begin
          // parent moves down into the hole
          cmd.wr_sel = WR_PARENT;
          cmd.pos_up = 1'b1;
          state_next = S_UP_CHK;
        end else begin
          cmd.wr_sel = WR_MOVING;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP_ROOT: begin
        cmd.cap_root  = 1'b1;
        cmd.rd_sel    = RD_LAST;
        cmd.dec_count = 1'b1;
        state_next    = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.load_last = 1'b1;
        if (stat.empty) begin
          cmd.emit    = 1'b1;
          cmd.res_src = RES_HELD;
          state_next  = S_IDLE;
        end else begin
          state_next = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (!stat.lc_valid) begin
          cmd.wr_sel  = WR_MOVING;
          cmd.emit    = 1'b1;
          cmd.res_src = RES_HELD;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        cmd.cap_left = 1'b1;
        if (stat.rc_valid) begin
          cmd.rd_sel = RD_RIGHT;
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.descend) begin
          cmd.wr_sel   = WR_CHILD;
          cmd.pos_down = 1'b1;
          state_next   = S_DN_CHK;
        end else begin
          cmd.wr_sel  = WR_MOVING;
          cmd.emit    = 1'b1;
          cmd.res_src = RES_HELD;
          state_next  = S_IDLE;
        end
      end
      S_PEEK: begin
        cmd.emit    = 1'b1;
        cmd.res_src = RES_RDATA;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bhpq_datapath.sv
// heap memory, count, hole position, compare logic and result registers
`timescale 1ns / 1ps
module bhpq_datapath
  import bhpq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic signed [KEY_W-1:0]   key,
  input  logic                      cfg_valid,
  input  logic                      cfg_data,
  output logic                      done,
  output logic [1:0]                status,
  output logic signed [KEY_W-1:0]   result_key,
  output logic [ENTRY_W-1:0]        entry_count
);

  logic [KEY_W-1:0]   mem [CAPACITY];
  logic [KEY_W-1:0]   rdata;
  logic [KEY_W-1:0]   moving;
  logic [KEY_W-1:0]   left;
  logic [KEY_W-1:0]   held;
  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  pos;
  logic               min_first;

  logic [CHILD_W-1:0] lc, rc, count_ext;
  logic [ADDR_W-1:0]  parent, last, pick_addr, raddr;
  logic [KEY_W-1:0]   best, pick_key, wdata;
  logic               best_is_l, r_wins, rd_en;

  assign count_ext = CHILD_W'(count);
  assign lc        = CHILD_W'({pos, 1'b1});
  assign rc        = lc + CHILD_W'(1);
  assign parent    = (pos - ADDR_W'(1)) >> 1;
  assign last      = ADDR_W'(count - CNT_W'(1));

  // left child must outrank the hole, right child must outrank the better of the two
  assign best_is_l = outranks(left, moving, min_first);
  assign best      = best_is_l ? left : moving;
  assign r_wins    = stat.rc_valid && outranks(rdata, best, min_first);
  assign pick_addr = r_wins ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
  assign pick_key  = r_wins ? rdata : left;

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CNT_W'(CAPACITY));
  assign stat.pos_zero = (pos == '0);
  assign stat.lc_valid = (lc < count_ext);
  assign stat.rc_valid = (rc < count_ext);
  assign stat.up_wins  = outranks(moving, rdata, min_first);
  assign stat.descend  = best_is_l || r_wins;

  always_comb begin
    rd_en = 1'b1;
    case (cmd.rd_sel)
      RD_ROOT:   raddr = '0;
      RD_LAST:   raddr = last;
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = lc[ADDR_W-1:0];
      RD_RIGHT:  raddr = rc[ADDR_W-1:0];
      default: begin
        raddr = '0;
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_PARENT: wdata = rdata;
      WR_CHILD:  wdata = pick_key;
      default:   wdata = moving;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      mem[pos] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      min_first <= 1'b1;
    end else begin
      if (cfg_valid) begin
        min_first <= cfg_data;
      end
      if (cmd.push_load) begin
        count <= count + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_load) begin
      moving <= key;
      pos    <= ADDR_W'(count);
    end else if (cmd.load_last) begin
      moving <= rdata;
      pos    <= '0;
    end else if (cmd.pos_up) begin
      pos <= parent;
    end else if (cmd.pos_down) begin
      pos <= pick_addr;
    end
    if (cmd.cap_left) begin
      left <= rdata;
    end
    if (cmd.cap_root) begin
      held <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.res_status;
      entry_count <= count_field(count);
      case (cmd.res_src)
        RES_RDATA: result_key <= rdata;
        RES_HELD:  result_key <= held;
        default:   result_key <= '0;
      endcase
    end
  end

endmodule

// File: sv/bhpq_checker.sv
// port-level checks of the binary heap priority queue, bound to the top level
`timescale 1ns / 1ps
module bhpq_checker
  import bhpq_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [1:0]              status,
  input logic signed [KEY_W-1:0] result_key,
  input logic [ENTRY_W-1:0]      entry_count
);

  // every accepted request is either finished next cycle or still in progress
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request neither in progress nor answered");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == count_field(CNT_W'(CAPACITY))))
    else $error("full status with count below capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (entry_count == '0 && result_key == '0))
    else $error("empty status with nonzero count or key");

  a_error_key: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_key == '0))
    else $error("error result carries a key");

  // no result without a request in flight or just accepted
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a request");

endmodule

bind binary_heap_priority_queue_top bhpq_checker u_bhpq_checker (.*);
